// ===== rtl/spti_pkg.sv =====
package spti_pkg;

  localparam logic [1:0] OP_INCR   = 2'd0;
  localparam logic [1:0] OP_REG    = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BADID    = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_IRQ    = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  counter_id;
    logic [31:0] threshold_value;
  } spti_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  point_id;
    logic [31:0] result_value;
    logic [1:0]  status;
    logic        last;
  } spti_out_t;

endpackage

// ===== rtl/spti_if.sv =====
interface spti_in_if;
  import spti_pkg::*;
  logic     valid;
  logic     ready;
  spti_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spti_out_if;
  import spti_pkg::*;
  logic      valid;
  logic      ready;
  spti_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/spti_slot_mem.sv =====
// Threshold slot store: one row per sync point, all slots of a row side by side.
module spti_slot_mem
  import spti_pkg::*;
#(
  parameter int DEPTH = 192,
  parameter int SLOTS = 8
) (
  input  logic                   clk,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [SLOTS*32-1:0]    rd_data,
  input  logic                   wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [SLOTS*32-1:0]    wr_data
);
  logic [SLOTS*32-1:0] mem [DEPTH];

  // Write row, then registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/spti_count_mem.sv =====
// Counter and fill store: count and fill count per sync point, cleared by a sweep.
module spti_count_mem
  import spti_pkg::*;
#(
  parameter int DEPTH = 192,
  parameter int FW    = 4
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [31+FW:0]           rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [31+FW:0]           wr_data
);
  logic [31+FW:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/syncpoint_threshold_interrupts_core.sv =====
// Flow: an accepted item passes the states S_RD and S_EXE (read, modify), then
// its first result is presented in S_FIRE or S_OUT and held until taken.
// One item at a time: in_ready stays low until its last result is taken; an
// increment yields an interrupt result per fired threshold, then a status result.
// Reset: synchronous active-low; after reset a clearing pass over all SYNC_POINTS
// rows zeroes counts and fill counts while in_ready stays low.
module syncpoint_threshold_interrupts_core
  import spti_pkg::*;
#(
  parameter int SYNC_POINTS     = 192,
  parameter int SLOTS_PER_POINT = 8
) (
  input  logic clk,
  input  logic rst_n,
  spti_in_if.sink   in_ch,
  spti_out_if.source out_ch
);
  localparam int AW = (SYNC_POINTS > 1) ? $clog2(SYNC_POINTS) : 1;
  localparam int FW = $clog2(SLOTS_PER_POINT + 1);
  localparam int SW = (SLOTS_PER_POINT > 1) ? $clog2(SLOTS_PER_POINT) : 1;
  localparam int RW = SLOTS_PER_POINT * 32;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EXE  = 3'd3;
  localparam logic [2:0] S_FIRE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic [AW-1:0]   clr_r;
  spti_in_t        item_r;
  logic [RW-1:0]   row_r;
  logic [31:0]     now_r;
  logic [SLOTS_PER_POINT-1:0] fire_r;
  logic            ov_r;
  spti_out_t       out_r;

  logic [AW-1:0]   addr;
  logic [RW-1:0]   srow;
  logic [31+FW:0]  crow;
  logic            s_we, c_we;
  logic [RW-1:0]   s_wd;
  logic [31+FW:0]  c_wd;
  logic [AW-1:0]   c_wa;

  logic            bad_id;
  assign bad_id = (32'(in_ch.data.counter_id) >= 32'(SYNC_POINTS));
  // Address the incoming item while idle, the held item afterwards
  assign addr = (state_r == S_IDLE) ? AW'(in_ch.data.counter_id) : AW'(item_r.counter_id);

  spti_slot_mem #(.DEPTH(SYNC_POINTS), .SLOTS(SLOTS_PER_POINT)) u_slots (
    .clk, .rd_addr(addr), .rd_data(srow),
    .wr_en(s_we), .wr_addr(AW'(item_r.counter_id)), .wr_data(s_wd));

  spti_count_mem #(.DEPTH(SYNC_POINTS), .FW(FW)) u_counts (
    .clk, .rd_addr(addr), .rd_data(crow),
    .wr_en(c_we), .wr_addr(c_wa), .wr_data(c_wd));

  // Slot compare and compaction, per row
  logic [31:0]   cur_cnt, incr;
  logic [FW-1:0] cur_fill;
  logic [SLOTS_PER_POINT-1:0] hit, ge;
  logic [RW-1:0] keep_row, del_row, add_row;
  logic [FW-1:0] keep_n;
  logic          any_hit;
  logic [SW-1:0] hit_pos;

  assign cur_cnt  = crow[31:0];
  assign cur_fill = (crow[31+FW:32] > FW'(SLOTS_PER_POINT)) ? FW'(SLOTS_PER_POINT)
                                                            : crow[31+FW:32];
  assign incr = cur_cnt + 32'd1;

  always_comb begin
    any_hit = 1'b0;
    hit_pos = '0;
    for (int i = 0; i < SLOTS_PER_POINT; i++) begin
      hit[i] = (FW'(i) < cur_fill) && (srow[i*32 +: 32] == item_r.threshold_value);
      ge[i]  = (FW'(i) < cur_fill) && (incr >= srow[i*32 +: 32]);
    end
    for (int i = SLOTS_PER_POINT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        hit_pos = SW'(i);
      end
    end
    // keep survivors in order
    keep_row = srow;
    keep_n   = '0;
    for (int i = 0; i < SLOTS_PER_POINT; i++) begin
      if ((FW'(i) < cur_fill) && !ge[i]) begin
        keep_row[keep_n[SW-1:0]*32 +: 32] = srow[i*32 +: 32];
        keep_n = keep_n + FW'(1);
      end
    end
    // shift down above the cancelled slot
    del_row = srow;
    for (int i = 0; i < SLOTS_PER_POINT - 1; i++) begin
      if (SW'(i) >= hit_pos) begin
        del_row[i*32 +: 32] = srow[(i+1)*32 +: 32];
      end
    end
    add_row = srow;
    for (int i = 0; i < SLOTS_PER_POINT; i++) begin
      if (FW'(i) == cur_fill) begin
        add_row[i*32 +: 32] = item_r.threshold_value;
      end
    end
  end

  // Write-back selection
  always_comb begin
    s_we = 1'b0;
    c_we = 1'b0;
    s_wd = keep_row;
    c_wd = {cur_fill, cur_cnt};
    c_wa = AW'(item_r.counter_id);
    if (state_r == S_CLR) begin
      c_we = 1'b1;
      c_wa = clr_r;
      c_wd = '0;
    end else if (state_r == S_EXE && !ov_r) begin
      case (item_r.operation)
        OP_INCR: begin
          s_we = 1'b1;
          c_we = 1'b1;
          c_wd = {keep_n, incr};
        end
        OP_REG: begin
          if (!any_hit && cur_fill < FW'(SLOTS_PER_POINT)) begin
            s_we = 1'b1;
            s_wd = add_row;
            c_we = 1'b1;
            c_wd = {cur_fill + FW'(1), cur_cnt};
          end
        end
        OP_CANCEL: begin
          if (any_hit) begin
            s_we = 1'b1;
            s_wd = del_row;
            c_we = 1'b1;
            c_wd = {cur_fill - FW'(1), cur_cnt};
          end
        end
        default: ;
      endcase
    end
  end

  // Next pending fired slot and what remains after it
  logic [SW-1:0] nxt_idx;
  logic [SLOTS_PER_POINT-1:0] rest;
  always_comb begin
    nxt_idx = '0;
    for (int i = SLOTS_PER_POINT - 1; i >= 0; i--) begin
      if (fire_r[i]) begin
        nxt_idx = SW'(i);
      end
    end
  end
  assign rest = fire_r & ~(SLOTS_PER_POINT'(1) << nxt_idx);

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT) || (state_r == S_FIRE);
  assign out_ch.data = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_r == AW'(SYNC_POINTS - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_ch.valid) state_nxt = S_RD;
      S_RD:   state_nxt = S_EXE;
      S_EXE:  state_nxt = (item_r.operation == OP_INCR && !ov_r && (|ge)) ? S_FIRE : S_OUT;
      S_FIRE: if (out_ch.ready) state_nxt = (|rest) ? S_FIRE : S_OUT;
      S_OUT:  if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + AW'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      item_r <= in_ch.data;
      ov_r   <= bad_id;
    end
    if (state_r == S_EXE) begin
      row_r  <= srow;
      fire_r <= (item_r.operation == OP_INCR && !ov_r) ? ge : '0;
      now_r  <= incr;
      out_r.kind     <= KIND_STATUS;
      out_r.point_id <= item_r.counter_id;
      out_r.status   <= ST_OK;
      out_r.last     <= 1'b1;
      if (ov_r) begin
        out_r.result_value <= '0;
        out_r.status <= ST_BADID;
      end else begin
        case (item_r.operation)
          OP_INCR:   out_r.result_value <= incr;
          OP_READ:   out_r.result_value <= cur_cnt;
          OP_REG: begin
            out_r.result_value <= item_r.threshold_value;
            if (!any_hit && cur_fill >= FW'(SLOTS_PER_POINT)) out_r.status <= ST_FULL;
          end
          default: begin
            out_r.result_value <= item_r.threshold_value;
            if (!any_hit) out_r.status <= ST_NOTFOUND;
          end
        endcase
        if (item_r.operation == OP_INCR && (|ge)) begin
          out_r.kind <= KIND_IRQ;
          out_r.last <= 1'b0;
          for (int i = SLOTS_PER_POINT - 1; i >= 0; i--) begin
            if (ge[i]) out_r.result_value <= srow[i*32 +: 32];
          end
        end
      end
    end else if (state_r == S_FIRE && out_ch.ready) begin
      fire_r[nxt_idx] <= 1'b0;
      if (|rest) begin
        for (int i = SLOTS_PER_POINT - 1; i >= 0; i--) begin
          if (rest[i]) out_r.result_value <= row_r[i*32 +: 32];
        end
      end else begin
        out_r.kind <= KIND_STATUS;
        out_r.last <= 1'b1;
        out_r.result_value <= now_r;
      end
    end
  end
endmodule

// ===== rtl/spti_checker.sv =====
module spti_checker
  import spti_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input spti_out_t out_data
);
  // No new item while a result is pending
  a_noov: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("item taken while result pending");
  // Interrupt results are never last and carry status OK
  a_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_IRQ |-> !out_data.last && out_data.status == ST_OK)
    else $error("bad interrupt result");
  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  // Accept leads to a result soon
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##2 out_valid) else $error("no result after item");
endmodule

bind syncpoint_threshold_interrupts_core spti_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
